>>> rtl/core/kpbt_pkg.sv
// shared constants, codes and types for the k-mer prefix bucket table
package kpbt_pkg;

	localparam int PREFIX_LEN  = 8;
	localparam int TABLE_DEPTH = 65536;
	localparam int BKT_BITS    = 2 * PREFIX_LEN;
	localparam int NUM_BUCKETS = 1 << BKT_BITS;
	localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = 17;
	localparam int POS_W       = CNT_W + 1;
	localparam int SFX_W       = 64 - BKT_BITS;
	localparam int SWEEP_N     = (NUM_BUCKETS > TABLE_DEPTH) ? NUM_BUCKETS : TABLE_DEPTH;
	localparam int SWEEP_BITS  = $clog2(SWEEP_N) + 1;
	localparam int MAX_K       = 32;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_UNKNOWN   = 3'd3;
	localparam logic [2:0] ST_OVERFLOW  = 3'd4;

	localparam logic [1:0] ACT_TALLY  = 2'd0;
	localparam logic [1:0] ACT_FINAL  = 2'd1;
	localparam logic [1:0] ACT_INSERT = 2'd2;
	localparam logic [1:0] ACT_LOOKUP = 2'd3;

	typedef struct packed {
		logic        start;
		logic [1:0]  action;
		logic [63:0] code;
		logic        unknown;
		logic [31:0] count;
		logic [5:0]  klen;
	} req_t;

	typedef struct packed {
		logic        valid;
		logic [2:0]  status;
		logic [31:0] count;
	} res_t;

endpackage

>>> rtl/core/kpbt_ram.sv
// generic simple dual port ram with registered read
module kpbt_ram #(
	parameter int W  = 8,
	parameter int AW = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [0:(1<<AW)-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/kpbt_alu.sv
// shared adder and comparator
module kpbt_alu (
	input  logic [kpbt_pkg::POS_W-1:0] a,
	input  logic [kpbt_pkg::POS_W-1:0] b,
	output logic [kpbt_pkg::POS_W:0]   sum,
	output logic                       lt
);

	assign sum = {1'b0, a} + {1'b0, b};
	assign lt  = a < b;

endmodule

>>> rtl/core/kpbt_seq.sv
// sequencer with bucket and entry stores
module kpbt_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  kpbt_pkg::req_t  req,
	input  logic            res_ready,
	output kpbt_pkg::res_t  res,
	output logic            idle
);

	localparam int CW = kpbt_pkg::CNT_W;
	localparam int PW = kpbt_pkg::POS_W;
	localparam int BB = kpbt_pkg::BKT_BITS;
	localparam int AB = kpbt_pkg::ADDR_BITS;
	localparam int SB = kpbt_pkg::SWEEP_BITS;
	localparam int SFX_WL = kpbt_pkg::SFX_W;

	localparam logic [4:0] S_CLR   = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_PREP  = 5'd2;
	localparam logic [4:0] S_T_RD  = 5'd3;
	localparam logic [4:0] S_T_WR  = 5'd4;
	localparam logic [4:0] S_I_RD  = 5'd5;
	localparam logic [4:0] S_I_CMP = 5'd6;
	localparam logic [4:0] S_I_ADD = 5'd7;
	localparam logic [4:0] S_I_CHK = 5'd8;
	localparam logic [4:0] S_I_WR  = 5'd9;
	localparam logic [4:0] S_L_RD  = 5'd10;
	localparam logic [4:0] S_L_LIM = 5'd11;
	localparam logic [4:0] S_L_POS = 5'd12;
	localparam logic [4:0] S_L_CMP = 5'd13;
	localparam logic [4:0] S_F_RD  = 5'd14;
	localparam logic [4:0] S_F_WR  = 5'd15;
	localparam logic [4:0] S_DONE  = 5'd16;

	localparam logic [CW-1:0] SIZE_MAX = {CW{1'b1}};
	localparam logic [PW-1:0] DEPTH    = PW'(kpbt_pkg::TABLE_DEPTH);

	logic [4:0]    state_q;
	logic [1:0]    act_q;
	logic [63:0]   key_q;
	logic [63:0]   rc_q;
	logic          unk_q;
	logic [31:0]   cnt_q;
	logic [5:0]    k_q;
	logic          pass_q;
	logic [SB-1:0] sweep_q;
	logic [PW-1:0] sum_q;
	logic [CW-1:0] off_q;
	logic [CW-1:0] cur_q;
	logic [PW-1:0] pos_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] lim_q;
	logic [2:0]    st_q;
	logic [31:0]   found_q;

	logic [5:0]    klen_eff;
	logic [6:0]    sh;
	logic [63:0]   cur_key;
	logic [BB-1:0] bkt;
	logic [63:0]   sfx;
	logic [63:0]   rc_full;
	logic [6:0]    rc_sh;

	logic [PW-1:0] alu_a;
	logic [PW-1:0] alu_b;
	logic [PW:0]   alu_sum;
	logic          alu_lt;
	logic [PW-1:0] fsum;

	logic          sz_we, off_we, cur_we, cn_we, sf_we;
	logic          sz_re, bk_re, cn_re, sf_re;
	logic [BB-1:0] sz_waddr, bk_waddr, sz_raddr;
	logic [AB-1:0] cn_waddr, cn_raddr;
	logic [CW-1:0] sz_wdata, off_wdata, cur_wdata;
	logic [31:0]   cn_wdata;
	logic [CW-1:0] sz_rd, off_rd, cur_rd;
	logic [31:0]   cn_rd;
	logic [SFX_WL-1:0] sf_rd;

	logic          sweep_in_bkt;
	logic          sweep_in_tab;
	logic          sweep_last;

	always_comb begin
		if (req.klen < 6'(kpbt_pkg::PREFIX_LEN)) begin
			klen_eff = 6'(kpbt_pkg::PREFIX_LEN);
		end else if (req.klen > 6'(kpbt_pkg::MAX_K)) begin
			klen_eff = 6'(kpbt_pkg::MAX_K);
		end else begin
			klen_eff = req.klen;
		end
	end

	assign sh      = {1'b0, k_q - 6'(kpbt_pkg::PREFIX_LEN)} << 1;
	assign cur_key = pass_q ? rc_q : key_q;
	assign bkt     = BB'(cur_key >> sh);
	assign sfx     = cur_key & ((64'd1 << sh) - 64'd1);

	always_comb begin
		for (int i = 0; i < 32; i++) begin
			rc_full[2*(31-i) +: 2] = ~key_q[2*i +: 2];
		end
	end
	assign rc_sh = 7'd64 - {k_q, 1'b0};

	kpbt_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sum (alu_sum),
		.lt  (alu_lt)
	);

	assign fsum = (alu_sum > {1'b0, DEPTH}) ? DEPTH + PW'(1) : alu_sum[PW-1:0];

	assign sweep_in_bkt = sweep_q < SB'(kpbt_pkg::NUM_BUCKETS);
	assign sweep_in_tab = sweep_q < SB'(kpbt_pkg::TABLE_DEPTH);
	assign sweep_last   = sweep_q == SB'(kpbt_pkg::SWEEP_N - 1);

	always_comb begin
		alu_a = '0;
		alu_b = '0;
		case (state_q)
			S_T_WR: begin
				alu_a = PW'(sz_rd);
				alu_b = PW'(1);
			end
			S_I_CMP, S_L_LIM: begin
				alu_a = PW'(cur_rd);
				alu_b = PW'(sz_rd);
			end
			S_I_ADD: begin
				alu_a = PW'(off_q);
				alu_b = PW'(cur_q);
			end
			S_I_WR: begin
				alu_a = PW'(cur_q);
				alu_b = PW'(1);
			end
			S_L_POS: begin
				alu_a = PW'(off_q);
				alu_b = PW'(idx_q);
			end
			S_F_WR: begin
				alu_a = sum_q;
				alu_b = sweep_in_bkt ? PW'(sz_rd) : '0;
			end
			default: begin
				alu_a = '0;
				alu_b = '0;
			end
		endcase
	end

	// memory ports
	always_comb begin
		sz_we     = 1'b0;
		off_we    = 1'b0;
		cur_we    = 1'b0;
		cn_we     = 1'b0;
		sf_we     = 1'b0;
		sz_waddr  = bkt;
		bk_waddr  = bkt;
		cn_waddr  = pos_q[AB-1:0];
		sz_wdata  = '0;
		off_wdata = '0;
		cur_wdata = '0;
		cn_wdata  = '0;
		sz_re     = 1'b0;
		bk_re     = 1'b0;
		cn_re     = 1'b0;
		sf_re     = 1'b0;
		sz_raddr  = bkt;
		cn_raddr  = pos_q[AB-1:0];
		case (state_q)
			S_CLR: begin
				sz_we    = sweep_in_bkt;
				off_we   = sweep_in_bkt;
				cur_we   = sweep_in_bkt;
				cn_we    = sweep_in_tab;
				sz_waddr = sweep_q[BB-1:0];
				bk_waddr = sweep_q[BB-1:0];
				cn_waddr = sweep_q[AB-1:0];
			end
			S_T_RD, S_I_RD, S_L_RD: begin
				sz_re = 1'b1;
				bk_re = 1'b1;
			end
			S_T_WR: begin
				sz_we    = sz_rd != SIZE_MAX;
				sz_wdata = alu_sum[CW-1:0];
			end
			S_I_CHK: begin
				cn_re = pos_q < DEPTH;
			end
			S_I_WR: begin
				cn_we     = cn_rd == 32'd0;
				sf_we     = cn_rd == 32'd0;
				cur_we    = cn_rd == 32'd0;
				cn_wdata  = cnt_q;
				cur_wdata = alu_sum[CW-1:0];
			end
			S_L_POS: begin
				cn_re    = 1'b1;
				sf_re    = 1'b1;
				cn_raddr = alu_sum[AB-1:0];
			end
			S_F_RD: begin
				sz_re    = sweep_in_bkt;
				sz_raddr = sweep_q[BB-1:0];
			end
			S_F_WR: begin
				off_we    = sweep_in_bkt;
				cur_we    = sweep_in_bkt;
				cn_we     = sweep_in_tab;
				bk_waddr  = sweep_q[BB-1:0];
				cn_waddr  = sweep_q[AB-1:0];
				off_wdata = (sum_q > DEPTH) ? DEPTH[CW-1:0] : sum_q[CW-1:0];
			end
			default: begin
				sz_we = 1'b0;
			end
		endcase
	end

	kpbt_ram #(.W(CW), .AW(BB)) u_size (
		.clk(clk), .we(sz_we), .waddr(sz_waddr), .wdata(sz_wdata),
		.re(sz_re), .raddr(sz_raddr), .rdata(sz_rd)
	);

	kpbt_ram #(.W(CW), .AW(BB)) u_offset (
		.clk(clk), .we(off_we), .waddr(bk_waddr), .wdata(off_wdata),
		.re(bk_re), .raddr(bkt), .rdata(off_rd)
	);

	kpbt_ram #(.W(CW), .AW(BB)) u_cursor (
		.clk(clk), .we(cur_we), .waddr(bk_waddr), .wdata(cur_wdata),
		.re(bk_re), .raddr(bkt), .rdata(cur_rd)
	);

	kpbt_ram #(.W(32), .AW(AB)) u_count (
		.clk(clk), .we(cn_we), .waddr(cn_waddr), .wdata(cn_wdata),
		.re(cn_re), .raddr(cn_raddr), .rdata(cn_rd)
	);

	kpbt_ram #(.W(SFX_WL), .AW(AB)) u_suffix (
		.clk(clk), .we(sf_we), .waddr(pos_q[AB-1:0]), .wdata(sfx[SFX_WL-1:0]),
		.re(sf_re), .raddr(alu_sum[AB-1:0]), .rdata(sf_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			sweep_q <= '0;
			pass_q  <= 1'b0;
		end else begin
			case (state_q)
				S_CLR: begin
					sweep_q <= sweep_q + SB'(1);
					if (sweep_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.start) begin
						pass_q <= 1'b0;
						if (req.action == kpbt_pkg::ACT_FINAL) begin
							sweep_q <= '0;
							state_q <= S_F_RD;
						end else if (req.unknown) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_PREP;
						end
					end
				end
				S_PREP: begin
					case (act_q)
						kpbt_pkg::ACT_TALLY:  state_q <= S_T_RD;
						kpbt_pkg::ACT_INSERT: state_q <= S_I_RD;
						default:              state_q <= S_L_RD;
					endcase
				end
				S_T_RD: state_q <= S_T_WR;
				S_T_WR: begin
					pass_q  <= 1'b1;
					state_q <= pass_q ? S_DONE : S_T_RD;
				end
				S_I_RD: state_q <= S_I_CMP;
				S_I_CMP: state_q <= alu_lt ? S_I_ADD : S_DONE;
				S_I_ADD: state_q <= S_I_CHK;
				S_I_CHK: state_q <= (pos_q < DEPTH) ? S_I_WR : S_DONE;
				S_I_WR: begin
					pass_q <= 1'b1;
					if (cn_rd != 32'd0 || pass_q) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_I_RD;
					end
				end
				S_L_RD: state_q <= S_L_LIM;
				S_L_LIM: state_q <= S_L_POS;
				S_L_POS: begin
					if (idx_q >= lim_q || alu_sum >= {1'b0, DEPTH}) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_L_CMP;
					end
				end
				S_L_CMP: state_q <= (sf_rd == sfx[SFX_WL-1:0]) ? S_DONE : S_L_POS;
				S_F_RD: state_q <= S_F_WR;
				S_F_WR: begin
					sweep_q <= sweep_q + SB'(1);
					state_q <= sweep_last ? S_DONE : S_F_RD;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				act_q   <= req.action;
				key_q   <= req.code;
				unk_q   <= req.unknown;
				cnt_q   <= req.count;
				k_q     <= klen_eff;
				sum_q   <= '0;
				found_q <= '0;
				st_q    <= req.unknown ? kpbt_pkg::ST_UNKNOWN : kpbt_pkg::ST_OK;
			end
			S_PREP: rc_q <= rc_full >> rc_sh;
			S_I_CMP: begin
				off_q <= off_rd;
				cur_q <= cur_rd;
				if (!alu_lt) begin
					st_q <= kpbt_pkg::ST_FULL;
				end
			end
			S_I_ADD: pos_q <= alu_sum[PW-1:0];
			S_I_CHK: begin
				if (pos_q >= DEPTH) begin
					st_q <= kpbt_pkg::ST_OVERFLOW;
				end
			end
			S_I_WR: begin
				if (cn_rd != 32'd0) begin
					st_q <= kpbt_pkg::ST_FULL;
				end
			end
			S_L_LIM: begin
				lim_q <= alu_lt ? cur_rd : sz_rd;
				off_q <= off_rd;
				idx_q <= '0;
				st_q  <= kpbt_pkg::ST_NOT_FOUND;
			end
			S_L_CMP: begin
				if (sf_rd == sfx[SFX_WL-1:0]) begin
					st_q    <= kpbt_pkg::ST_OK;
					found_q <= cn_rd;
				end
				idx_q <= idx_q + CW'(1);
			end
			S_F_WR: begin
				sum_q <= fsum;
				if (sweep_last) begin
					st_q <= (fsum > DEPTH) ? kpbt_pkg::ST_OVERFLOW : kpbt_pkg::ST_OK;
				end
			end
			default: begin
				found_q <= found_q;
			end
		endcase
	end

	assign idle       = state_q == S_IDLE;
	assign res.valid  = state_q == S_DONE;
	assign res.status = st_q;
	assign res.count  = (unk_q || st_q != kpbt_pkg::ST_OK) ? 32'd0 : found_q;

endmodule

>>> rtl/core/kmer_prefix_bucket_table.sv
// top level of the k-mer prefix bucket table
// after reset a clearing pass zeroes sizes, offsets, cursors and counts
// finalize sweeps every bucket, reading each size through the size store port
// one item at a time; a result waits in the output register while the next item runs
// arst_n clears control state; kmer_length resets to 25
module kmer_prefix_bucket_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [5:0]  kmer_length,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [63:0] kmer_code,
	input  logic        has_unknown,
	input  logic [31:0] count_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] stored_count
);

	logic [5:0]     klen_q;
	logic           out_valid_q;
	logic [2:0]     status_q;
	logic [31:0]    count_q;
	logic           idle;
	logic           res_ready;
	kpbt_pkg::req_t req;
	kpbt_pkg::res_t res;

	assign cfg_ready = 1'b1;
	assign in_stall  = !idle;
	assign res_ready = !out_valid_q || !out_stall;

	assign req.start   = in_valid && idle;
	assign req.action  = action;
	assign req.code    = kmer_code;
	assign req.unknown = has_unknown;
	assign req.count   = count_value;
	assign req.klen    = klen_q;

	kpbt_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res_ready (res_ready),
		.res       (res),
		.idle      (idle)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			klen_q      <= 6'd25;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				klen_q <= kmer_length;
			end
			if (res.valid && res_ready) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && res_ready) begin
			status_q <= res.status;
			count_q  <= res.count;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign stored_count = count_q;

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= kpbt_pkg::ST_OVERFLOW)
		else $error("status code out of range");

	a_count_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stored_count != 32'd0 |-> status == kpbt_pkg::ST_OK)
		else $error("count returned with failing status");

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> in_stall)
		else $error("input open while result pending");

endmodule
